FILE: hdl/udprx_pkg.sv
// ----------------------------------------------------------------------------
// udprx_pkg
// Shared types and constants of the UDP receive filter: register indexes,
// reset values, frame layout offsets and the result record.
// ----------------------------------------------------------------------------
package udprx_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LISTEN_PORT    = 2'd0,
    CFG_SERVER_ADDRESS = 2'd1,
    CFG_SERVER_PORT    = 2'd2
  } cfg_index_t;

  // register reset values
  localparam logic [15:0] LISTEN_PORT_RST    = 16'd6666;
  localparam logic [31:0] SERVER_ADDRESS_RST = 32'h0A00_020A;
  localparam logic [15:0] SERVER_PORT_RST    = 16'd8622;

  // frame layout
  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] IP_PROTO_OFF  = 16'd23;
  localparam logic [15:0] IP_SADDR_OFF  = 16'd26;
  localparam logic [15:0] IP_SADDR_LAST = 16'd29;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [7:0]  UDP_PROTO     = 8'd17;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;

  // current register values
  typedef struct packed {
    logic [15:0] listen_port;
    logic [31:0] server_address;
    logic [15:0] server_port;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_end;
    logic        accepted;
    logic [15:0] udp_frames_seen;
  } result_t;

endpackage

FILE: hdl/udprx_in_if.sv
// ----------------------------------------------------------------------------
// udprx_in_if
// Frame byte channel: valid/ready handshake with one byte and a last mark.
// ----------------------------------------------------------------------------
interface udprx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

FILE: hdl/udprx_out_if.sv
// ----------------------------------------------------------------------------
// udprx_out_if
// Result channel: valid/ready handshake with payload byte and frame status.
// ----------------------------------------------------------------------------
interface udprx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_end;
  logic        accepted;
  logic [15:0] udp_frames_seen;

  modport source (
    output valid, output payload_byte, output payload_valid, output frame_end,
    output accepted, output udp_frames_seen, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input frame_end,
    input accepted, input udp_frames_seen, output ready
  );
endinterface

FILE: hdl/udp_receive_filter_payload_extract.sv
// A result item appears in the result register in the cycle after the
// frame byte that causes it is accepted.
// Throughput: one frame byte per cycle while the result register is free or
// being drained; a waiting result item holds off the input until the sink takes it.
// Reset (rst, synchronous): frame state and frame counter cleared, registers
// back to their defaults, result register empty.
// ----------------------------------------------------------------------------
// udp_receive_filter_payload_extract
// Ethernet/IPv4/UDP receive filter: checks protocol, ports and server
// address of each frame and passes the UDP payload of matching frames.
// ----------------------------------------------------------------------------
module udp_receive_filter_payload_extract (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [udprx_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [udprx_pkg::CFG_DATA_W-1:0]    cfg_data,
  udprx_in_if.sink                            frame_in,
  udprx_out_if.source                         result_out
);
  import udprx_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    emit;
  logic    space;
  logic    res_valid;
  result_t res_next;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_port    <= LISTEN_PORT_RST;
      cfg.server_address <= SERVER_ADDRESS_RST;
      cfg.server_port    <= SERVER_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LISTEN_PORT:    cfg.listen_port    <= cfg_data[15:0];
        CFG_SERVER_ADDRESS: cfg.server_address <= cfg_data[31:0];
        CFG_SERVER_PORT:    cfg.server_port    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign frame_in.ready = space;
  assign accept = frame_in.valid && space;

  // header tracking and match
  udprx_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_in.frame_byte),
    .frame_last (frame_in.frame_last),
    .cfg        (cfg),
    .emit       (emit),
    .result     (res_next)
  );

  // result register
  udprx_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .load_data  (res_next),
    .sink_ready (result_out.ready),
    .space      (space),
    .valid      (res_valid),
    .data       (res)
  );

  // output channel
  assign result_out.valid           = res_valid;
  assign result_out.payload_byte    = res.payload_byte;
  assign result_out.payload_valid   = res.payload_valid;
  assign result_out.frame_end       = res.frame_end;
  assign result_out.accepted        = res.accepted;
  assign result_out.udp_frames_seen = res.udp_frames_seen;

endmodule

FILE: hdl/udprx_parse.sv
// ----------------------------------------------------------------------------
// udprx_parse
// Per-frame header tracking: captures IPv4 header length, protocol and source
// address and the UDP ports, and forms the result of each accepted byte.
// ----------------------------------------------------------------------------
module udprx_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        frame_byte,
  input  logic              frame_last,
  input  udprx_pkg::cfg_t   cfg,
  output logic              emit,
  output udprx_pkg::result_t result
);
  import udprx_pkg::*;

  logic [15:0] byte_offset;
  logic [3:0]  header_words;
  logic        protocol_is_udp;
  logic [31:0] source_address_seen;
  logic [15:0] source_port_seen;
  logic [15:0] dest_port_seen;
  logic [15:0] udp_frame_count;

  logic [15:0] byte_offset_next;
  logic [3:0]  header_words_next;
  logic        protocol_is_udp_next;
  logic [31:0] source_address_seen_next;
  logic [15:0] source_port_seen_next;
  logic [15:0] dest_port_seen_next;
  logic [15:0] udp_frame_count_next;

  logic [15:0] udp_start;
  logic        hdr_ok;
  logic        match;
  logic        payload;
  logic        proto_hit;

  // header field capture for the current byte
  always_comb begin
    header_words_next = (byte_offset == ETH_HDR_LEN) ? frame_byte[3:0] : header_words;
    udp_start = ETH_HDR_LEN + {10'd0, header_words_next, 2'b00};
    hdr_ok = (header_words_next >= MIN_HDR_WORDS);

    proto_hit = (byte_offset == IP_PROTO_OFF) && (frame_byte == UDP_PROTO);
    protocol_is_udp_next = (byte_offset == IP_PROTO_OFF) ? proto_hit : protocol_is_udp;
    udp_frame_count_next = proto_hit ? udp_frame_count + 16'd1 : udp_frame_count;

    source_address_seen_next = source_address_seen;
    if (byte_offset >= IP_SADDR_OFF && byte_offset <= IP_SADDR_LAST) begin
      source_address_seen_next = {source_address_seen[23:0], frame_byte};
    end

    source_port_seen_next = source_port_seen;
    dest_port_seen_next   = dest_port_seen;
    if (hdr_ok) begin
      if (byte_offset == udp_start || byte_offset == udp_start + 16'd1) begin
        source_port_seen_next = {source_port_seen[7:0], frame_byte};
      end
      if (byte_offset == udp_start + 16'd2 || byte_offset == udp_start + 16'd3) begin
        dest_port_seen_next = {dest_port_seen[7:0], frame_byte};
      end
    end

    match = protocol_is_udp_next && hdr_ok &&
            (byte_offset >= udp_start + 16'd3) &&
            (dest_port_seen_next == cfg.listen_port) &&
            (source_address_seen_next == cfg.server_address) &&
            (source_port_seen_next == cfg.server_port);
    payload = match && (byte_offset >= udp_start + UDP_HDR_LEN);

    byte_offset_next = (byte_offset == OFFSET_MAX) ? byte_offset : byte_offset + 16'd1;
  end

  // result of this byte
  always_comb begin
    emit = payload || frame_last;
    result.payload_byte    = payload ? frame_byte : 8'd0;
    result.payload_valid   = payload;
    result.frame_end       = frame_last;
    result.accepted        = match;
    result.udp_frames_seen = udp_frame_count_next;
  end

  // frame state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset         <= '0;
      header_words        <= '0;
      protocol_is_udp     <= 1'b0;
      source_address_seen <= '0;
      source_port_seen    <= '0;
      dest_port_seen      <= '0;
      udp_frame_count     <= '0;
    end else if (accept) begin
      udp_frame_count <= udp_frame_count_next;
      if (frame_last) begin
        byte_offset         <= '0;
        header_words        <= '0;
        protocol_is_udp     <= 1'b0;
        source_address_seen <= '0;
        source_port_seen    <= '0;
        dest_port_seen      <= '0;
      end else begin
        byte_offset         <= byte_offset_next;
        header_words        <= header_words_next;
        protocol_is_udp     <= protocol_is_udp_next;
        source_address_seen <= source_address_seen_next;
        source_port_seen    <= source_port_seen_next;
        dest_port_seen      <= dest_port_seen_next;
      end
    end
  end

endmodule

FILE: hdl/udprx_out_reg.sv
// ----------------------------------------------------------------------------
// udprx_out_reg
// Result register: holds one item for the sink and frees its slot in the
// same cycle the sink takes it.
// ----------------------------------------------------------------------------
module udprx_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  udprx_pkg::result_t load_data,
  input  logic               sink_ready,
  output logic               space,
  output logic               valid,
  output udprx_pkg::result_t data
);
  import udprx_pkg::*;

  // slot is free when empty or being drained
  assign space = !valid || sink_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (sink_ready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
